FILE: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared widths, job types and the divisor reciprocal table of the
// triangular window smoother.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RADIUS  = 7;
    localparam int CFG_BITS    = 3;
    localparam int TAPS        = 2 * MAX_RADIUS + 1;
    localparam int R_BITS      = $clog2(MAX_RADIUS + 1);
    localparam int WEIGHT_BITS = $clog2(MAX_RADIUS + 2);
    localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int TOTAL_LOG   = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1));
    localparam int SUM_BITS    = SAMPLE_BITS + TOTAL_LOG + 1;
    localparam int MAG_BITS    = SUM_BITS - 1;
    localparam int RECIP_SHIFT = MAG_BITS + TOTAL_LOG;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int WIDE_BITS   = MAG_BITS + RECIP_BITS;
    localparam int COUNT_BITS  = $clog2(2 * MAX_RADIUS + 1);
    localparam int NRES_BITS   = $clog2(MAX_RADIUS + 2);
    localparam int GROUP       = 4;
    localparam int GROUPS      = (TAPS + GROUP - 1) / GROUP;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [R_BITS-1:0]             t_radius;

    typedef struct packed {
        logic                 use_mean;
        logic [NRES_BITS-1:0] n_results;
        logic                 last;
    } t_tag;

    typedef struct packed {
        t_sum sum;
        t_tag tag;
    } t_job;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  valid;
    } t_queue_status;

    typedef logic [MAX_RADIUS:0][RECIP_BITS-1:0] t_recip_table;

    function automatic logic [RECIP_BITS-1:0] ceil_recip(input int unsigned r);
        longint unsigned d;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned quo;
        int i;
        d   = longint'((r + 1) * (r + 1));
        num = (64'd1 << RECIP_SHIFT) + d - 64'd1;
        rem = 0;
        quo = 0;
        for (i = 62; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            quo = quo << 1;
            if (rem >= d) begin
                rem = rem - d;
                quo = quo | 64'd1;
            end
        end
        return RECIP_BITS'(quo);
    endfunction

    function automatic t_recip_table build_recip_table();
        t_recip_table t;
        int r;
        for (r = 0; r <= MAX_RADIUS; r++) begin
            t[r] = ceil_recip(r);
        end
        return t;
    endfunction

    localparam t_recip_table RECIP_TABLE = build_recip_table();

endpackage

FILE: hdl/tws_queue.sv
// ----------------------------------------------------------------------------
// tws_queue
// Job queue between the front end and the divide back end.
// ----------------------------------------------------------------------------
module tws_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  tws_pkg::t_job          i_job,
    input  logic                   i_pop,
    output tws_pkg::t_job          o_head,
    output tws_pkg::t_queue_status o_status
);

    tws_pkg::t_job                      r_mem [tws_pkg::QUEUE_DEPTH];
    logic [tws_pkg::QPTR_BITS-1:0]      r_wr;
    logic [tws_pkg::QPTR_BITS-1:0]      r_rd;
    logic [tws_pkg::LEVEL_BITS-1:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.level = r_level;
    assign o_status.valid = (r_level != '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level != tws_pkg::LEVEL_BITS'(tws_pkg::QUEUE_DEPTH)))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_level != '0))
        else $error("job popped from an empty queue");

endmodule

FILE: hdl/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front
// Accepts samples, keeps the delay line and frame count, classifies each
// sample and forms the weighted window sum in a three stage pipeline.
// ----------------------------------------------------------------------------
module tws_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tws_pkg::t_radius       i_radius,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tws_pkg::t_sample       i_sample,
    input  logic                   i_is_last,
    input  tws_pkg::t_queue_status i_status,
    output logic                   o_push,
    output tws_pkg::t_job          o_job
);

    tws_pkg::t_sample                 r_taps [tws_pkg::TAPS];
    logic [tws_pkg::COUNT_BITS-1:0]   r_seen;
    logic                             r_v1;
    logic                             r_v2;
    logic                             r_v3;
    tws_pkg::t_tag                    r_j1;
    tws_pkg::t_tag                    r_j2;
    tws_pkg::t_tag                    r_j3;
    tws_pkg::t_prod                   r_prod [tws_pkg::TAPS];
    tws_pkg::t_sum                    r_grp [tws_pkg::GROUPS];

    logic                             accept;
    logic [tws_pkg::LEVEL_BITS:0]     occupied;
    logic [tws_pkg::COUNT_BITS-1:0]   two_r;
    logic                             ge_r;
    logic                             ge_2r;
    logic [tws_pkg::NRES_BITS-1:0]    n_results;
    logic [tws_pkg::COUNT_BITS-1:0]   n_seen;
    tws_pkg::t_prod                   prod_a [tws_pkg::TAPS];
    tws_pkg::t_sum                    grp_a [tws_pkg::GROUPS];
    tws_pkg::t_sum                    total;

    assign occupied = (tws_pkg::LEVEL_BITS + 1)'(i_status.level)
                    + (tws_pkg::LEVEL_BITS + 1)'(r_v1)
                    + (tws_pkg::LEVEL_BITS + 1)'(r_v2)
                    + (tws_pkg::LEVEL_BITS + 1)'(r_v3);
    assign o_in_stall = !i_rst_n
                      || (occupied >= (tws_pkg::LEVEL_BITS + 1)'(tws_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    assign two_r = tws_pkg::COUNT_BITS'(i_radius) << 1;
    assign ge_r  = (r_seen >= tws_pkg::COUNT_BITS'(i_radius));
    assign ge_2r = (r_seen >= two_r);

    always_comb begin
        if (i_is_last) begin
            n_results = ge_r ? (tws_pkg::NRES_BITS'(i_radius) + 1'b1)
                             : (tws_pkg::NRES_BITS'(r_seen) + 1'b1);
            n_seen    = '0;
        end else begin
            n_results = ge_r ? tws_pkg::NRES_BITS'(1) : '0;
            n_seen    = ge_2r ? two_r : (r_seen + 1'b1);
        end
    end

    always_comb begin
        int w;
        for (int p = 0; p < tws_pkg::TAPS; p++) begin
            if (p <= int'(i_radius)) begin
                w = p + 1;
            end else if (p <= 2 * int'(i_radius)) begin
                w = 2 * int'(i_radius) - p + 1;
            end else begin
                w = 0;
            end
            prod_a[p] = tws_pkg::t_prod'(r_taps[p])
                      * $signed({1'b0, tws_pkg::WEIGHT_BITS'(w)});
        end
    end

    always_comb begin
        for (int g = 0; g < tws_pkg::GROUPS; g++) begin
            grp_a[g] = '0;
            for (int i = 0; i < tws_pkg::GROUP; i++) begin
                if (g * tws_pkg::GROUP + i < tws_pkg::TAPS) begin
                    grp_a[g] = grp_a[g]
                             + tws_pkg::t_sum'(r_prod[g * tws_pkg::GROUP + i]);
                end
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < tws_pkg::GROUPS; g++) begin
            total = total + r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < tws_pkg::TAPS; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_j1 <= '{use_mean: ge_2r, n_results: n_results, last: i_is_last};
        end
        r_prod <= prod_a;
        r_grp  <= grp_a;
        r_j2   <= r_j1;
        r_j3   <= r_j2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (accept) begin
                r_seen <= n_seen;
            end
            r_v1 <= accept && (n_results != '0);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_push    = r_v3;
    assign o_job.sum = total;
    assign o_job.tag = r_j3;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_is_last) |=> (r_seen == '0))
        else $error("frame count not cleared after last beat");

endmodule

FILE: hdl/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back
// Divides the window sum by (r+1)^2 through a reciprocal multiply and expands
// each job into its result beats behind an output register.
// ----------------------------------------------------------------------------
module tws_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tws_pkg::t_radius       i_radius,
    input  tws_pkg::t_job          i_head,
    input  tws_pkg::t_queue_status i_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tws_pkg::t_sample       o_smoothed,
    output logic                   o_last_out
);

    logic                             r_d1_valid;
    tws_pkg::t_tag                    r_d1_tag;
    logic                             r_d1_neg;
    logic [tws_pkg::MAG_BITS-1:0]     r_d1_mag;
    logic                             r_d2_valid;
    tws_pkg::t_tag                    r_d2_tag;
    logic                             r_d2_neg;
    logic [tws_pkg::WIDE_BITS-1:0]    r_d2_prod;
    logic                             r_d3_valid;
    tws_pkg::t_tag                    r_d3_tag;
    tws_pkg::t_sample                 r_d3_q;
    logic                             r_ex_valid;
    tws_pkg::t_sample                 r_ex_val;
    logic [tws_pkg::NRES_BITS-1:0]    r_ex_left;
    logic                             r_ex_last;
    logic                             r_out_valid;
    tws_pkg::t_sample                 r_smoothed;
    logic                             r_last_out;

    logic                             out_free;
    logic                             emit;
    logic                             ex_load;
    logic                             d3_free;
    logic                             d2_free;
    logic                             d1_free;
    logic [tws_pkg::MAG_BITS-1:0]     q_mag;
    logic [tws_pkg::MAG_BITS-1:0]     q_signed;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_ex_valid && out_free;
    assign ex_load  = !r_ex_valid || (emit && (r_ex_left == tws_pkg::NRES_BITS'(1)));
    assign d3_free  = !r_d3_valid || ex_load;
    assign d2_free  = !r_d2_valid || d3_free;
    assign d1_free  = !r_d1_valid || d2_free;
    assign o_pop    = i_status.valid && d1_free;

    assign q_mag    = tws_pkg::MAG_BITS'(r_d2_prod >> tws_pkg::RECIP_SHIFT);
    assign q_signed = r_d2_neg ? (~q_mag + 1'b1) : q_mag;

    always_ff @(posedge i_clk) begin
        if (d1_free) begin
            r_d1_tag <= i_head.tag;
            r_d1_neg <= i_head.sum[tws_pkg::SUM_BITS-1];
            r_d1_mag <= i_head.sum[tws_pkg::SUM_BITS-1]
                      ? tws_pkg::MAG_BITS'(-i_head.sum)
                      : tws_pkg::MAG_BITS'(i_head.sum);
        end
        if (d2_free) begin
            r_d2_tag  <= r_d1_tag;
            r_d2_neg  <= r_d1_neg;
            r_d2_prod <= tws_pkg::WIDE_BITS'(r_d1_mag)
                       * tws_pkg::WIDE_BITS'(tws_pkg::RECIP_TABLE[i_radius]);
        end
        if (d3_free) begin
            r_d3_tag <= r_d2_tag;
            r_d3_q   <= r_d2_tag.use_mean ? q_signed[tws_pkg::SAMPLE_BITS-1:0] : '0;
        end
        if (ex_load) begin
            r_ex_val  <= r_d3_q;
            r_ex_left <= r_d3_tag.n_results;
            r_ex_last <= r_d3_tag.last;
        end else if (emit) begin
            r_ex_val  <= '0;
            r_ex_left <= r_ex_left - 1'b1;
        end
        if (out_free) begin
            r_smoothed <= r_ex_val;
            r_last_out <= r_ex_last && (r_ex_left == tws_pkg::NRES_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid  <= 1'b0;
            r_d2_valid  <= 1'b0;
            r_d3_valid  <= 1'b0;
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (d1_free) begin
                r_d1_valid <= o_pop;
            end
            if (d2_free) begin
                r_d2_valid <= r_d1_valid;
            end
            if (d3_free) begin
                r_d3_valid <= r_d2_valid;
            end
            if (ex_load) begin
                r_ex_valid <= r_d3_valid;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_smoothed  = r_smoothed;
    assign o_last_out  = r_last_out;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_valid |-> (r_ex_left != '0))
        else $error("expander holds a job with no beats left");

endmodule

FILE: hdl/triangular_window_smoother_top.sv
// ----------------------------------------------------------------------------
// triangular_window_smoother_top
// Triangular weighted moving average over a frame of signed samples.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | i_in_valid/o_in_stall  | i_sample, i_is_last
//   out     | output    | o_out_valid/i_out_stall| o_smoothed, o_last_out
//   cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_window_radius
//
// A sample is taken every cycle while the eight entry job queue has room.
// Each sample gives zero, one or (last of frame) up to r+1 result beats; the
// output register sends one beat per cycle, so the output port sets the rate.
// From input beat to first result beat a job passes the front pipeline, the job
// queue, the divide stages, the expander and the output register. Reset is
// synchronous: radius goes to 1, the frame count clears and the job queue
// empties; the input stalls and the config port is not ready while reset is
// held. A stall on the output backs up the divide pipeline and then the queue.
module triangular_window_smoother_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tws_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tws_pkg::SAMPLE_BITS-1:0] o_smoothed,
    output logic                          o_last_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tws_pkg::CFG_BITS-1:0]  i_cfg_window_radius
);

    logic [tws_pkg::CFG_BITS-1:0]  r_window_radius;
    tws_pkg::t_radius              radius;
    logic                          push;
    logic                          pop;
    tws_pkg::t_job                 push_job;
    tws_pkg::t_job                 head_job;
    tws_pkg::t_queue_status        status;
    tws_pkg::t_sample              smoothed;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_radius <= tws_pkg::CFG_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_radius <= i_cfg_window_radius;
        end
    end

    assign radius = (int'(r_window_radius) > tws_pkg::MAX_RADIUS)
                  ? tws_pkg::R_BITS'(tws_pkg::MAX_RADIUS)
                  : tws_pkg::R_BITS'(r_window_radius);

    tws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_radius   (radius),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_is_last  (i_is_last),
        .i_status   (status),
        .o_push     (push),
        .o_job      (push_job)
    );

    tws_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (status)
    );

    tws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (radius),
        .i_head      (head_job),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_smoothed  (smoothed),
        .o_last_out  (o_last_out)
    );

    assign o_smoothed = smoothed;

endmodule

FILE: dv/triangular_window_smoother_top_test.sv
// ----------------------------------------------------------------------------
// triangular_window_smoother_top_test
// Drives framed sample streams through the smoother under several radius
// settings with random input gaps and random output stalls. A local model of
// the triangular weighted average predicts every result beat, and the monitor
// compares each beat received against the oldest prediction.
// ----------------------------------------------------------------------------
module triangular_window_smoother_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        tws_pkg::t_sample sample;
        logic             is_last;
    } t_sample_beat;

    typedef struct {
        tws_pkg::t_sample smoothed;
        logic             last_out;
    } t_average_beat;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [tws_pkg::SAMPLE_BITS-1:0] i_sample = '0;
    logic                            i_is_last = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [tws_pkg::SAMPLE_BITS-1:0] o_smoothed;
    logic                            o_last_out;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tws_pkg::CFG_BITS-1:0]    i_cfg_window_radius = '0;

    t_sample_beat  samples_to_send[$];
    t_average_beat averages_due[$];
    t_sample_beat  next_beat;
    t_average_beat got_beat;

    tws_pkg::t_sample taps[tws_pkg::TAPS];
    int               frame_count = 0;
    int               radius_setting = 1;
    int               samples_queued = 0;
    int               samples_taken = 0;
    int               mismatches = 0;
    int               send_idle_pct = 28;
    int               stall_pct = 60;

    triangular_window_smoother_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample            (i_sample),
        .i_is_last           (i_is_last),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_smoothed          (o_smoothed),
        .o_last_out          (o_last_out),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_radius (i_cfg_window_radius)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic smooth_step(input tws_pkg::t_sample s, input logic last);
        int r;
        int c;
        int n;
        int p;
        int w;
        longint acc;
        tws_pkg::t_sample first;
        t_average_beat b;
        r = (radius_setting > tws_pkg::MAX_RADIUS) ? tws_pkg::MAX_RADIUS : radius_setting;
        c = frame_count;
        for (p = tws_pkg::TAPS - 1; p > 0; p--) begin
            taps[p] = taps[p-1];
        end
        taps[0] = s;
        first = '0;
        if (c >= 2 * r) begin
            acc = 0;
            for (p = 0; p <= 2 * r; p++) begin
                w = (p <= r) ? p + 1 : 2 * r - p + 1;
                acc += longint'(taps[p]) * w;
            end
            first = tws_pkg::t_sample'(acc / ((r + 1) * (r + 1)));
        end
        if (last) begin
            n = (c >= r) ? r + 1 : c + 1;
        end else begin
            n = (c >= r) ? 1 : 0;
        end
        for (p = 0; p < n; p++) begin
            b.smoothed = (p == 0) ? first : '0;
            b.last_out = last && (p + 1 == n);
            averages_due.push_back(b);
        end
        if (last) begin
            frame_count = 0;
        end else begin
            frame_count = (c + 1 > 2 * r) ? 2 * r : c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                smooth_step(tws_pkg::t_sample'(i_sample), i_is_last);
                samples_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = samples_to_send.pop_front();
                    i_sample   <= next_beat.sample;
                    i_is_last  <= next_beat.is_last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (averages_due.size() == 0) begin
                $error("unexpected beat: smoothed %0d last_out %0b",
                       tws_pkg::t_sample'(o_smoothed), o_last_out);
                mismatches++;
            end else begin
                got_beat = averages_due.pop_front();
                if (tws_pkg::t_sample'(o_smoothed) !== got_beat.smoothed) begin
                    $error("smoothed: expected %0d, actual %0d",
                           got_beat.smoothed, tws_pkg::t_sample'(o_smoothed));
                    mismatches++;
                end
                if (o_last_out !== got_beat.last_out) begin
                    $error("last_out: expected %0b, actual %0b",
                           got_beat.last_out, o_last_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_sample(input int s, input logic last);
        t_sample_beat b;
        b.sample  = tws_pkg::t_sample'(s);
        b.is_last = last;
        samples_to_send.push_back(b);
        samples_queued++;
    endtask

    function automatic int pick_sample();
        int v;
        case ($urandom_range(9))
            0: v = 32767;
            1: v = -32768;
            2, 3: v = int'($urandom_range(64)) - 32;
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_frames(input int count);
        int queued;
        int len;
        int two_r;
        int k;
        bit close;
        queued = 0;
        while (queued < count) begin
            two_r = 2 * radius_setting;
            if ($urandom_range(99) < 15) begin
                len = $urandom_range(1, (two_r == 0) ? 1 : two_r);
            end else begin
                len = $urandom_range(two_r + 1, two_r + 8);
            end
            close = ($urandom_range(99) < 92);
            for (k = 0; k < len; k++) begin
                queue_sample(pick_sample(), close && (k == len - 1));
            end
            queued += len;
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (samples_taken != samples_queued || averages_due.size() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [tws_pkg::CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_window_radius <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius_setting = int'(value);
    endtask

    initial begin
        foreach (taps[p]) taps[p] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_sample(32767, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(32767, 1'b1);
        queue_sample(-32768, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(-32768, 1'b1);
        queue_sample(5, 1'b1);
        queue_sample(7, 1'b0);
        queue_sample(-3, 1'b1);
        settle();
        write_radius(3'd0);
        queue_sample('h1234, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b1);
        settle();
        write_radius(3'd7);
        queue_sample(32767, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(1, 1'b1);
        settle();
        write_radius(3'd2);
        queue_sample(100, 1'b0);
        queue_sample(-200, 1'b0);
        queue_sample(300, 1'b0);
        settle();
        write_radius(3'd5);
        queue_sample(7, 1'b1);
        settle();

        write_radius(3'd3);
        queue_frames(12);
        drain();
        queue_frames(10);
        settle();

        send_idle_pct = 60;
        stall_pct     = 28;
        write_radius(3'd7);
        queue_frames(24);
        settle();

        send_idle_pct = 0;
        stall_pct     = 0;
        write_radius(3'd0);
        queue_frames(6);
        settle();
        write_radius(3'd4);
        queue_frames(12);
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tws_pkg.sv
hdl/tws_queue.sv
hdl/tws_front.sv
hdl/tws_back.sv
hdl/triangular_window_smoother_top.sv
dv/triangular_window_smoother_top_test.sv
